// ===== design/all_pairs_shortest_path_table_assert.svh =====
// Assertion macros for the shortest-path table. The block's own checks use
// these so that one switch turns them all off.
`ifndef ALL_PAIRS_SHORTEST_PATH_TABLE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

`define APSPT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define APSPT_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define APSPT_ASSERT(name, clk, rst_n, prop, msg)

`define APSPT_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/apspt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apspt_pkg
// Types, codes and field widths shared by the shortest-path table modules.
// ----------------------------------------------------------------------------
package apspt_pkg;

	localparam int OPCODE_W = 2;
	localparam int NODE_W   = 5;
	localparam int WEIGHT_W = 20;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int SUM_W    = WEIGHT_W + 1;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Distance that stands for "no edge" or "unreachable".
	localparam logic [WEIGHT_W-1:0] NO_EDGE = 20'd999999;

	// Word index of the node count register on the configuration port.
	localparam logic [PADDR_W-3:0] REG_NODE_COUNT = 1'b0;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_SET_EDGE = 2'd1,
		OP_QUERY    = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_SELF  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// What the controller has to do with a captured request.
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_EDGE  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic capture;
		logic init_step;
		logic edge_ab;
		logic edge_ba;
		logic copy_step;
		logic ik_read;
		logic ik_load;
		logic relax_step;
		logic query_read;
		logic query_load;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  sweep_last;
		logic  j_last;
		logic  i_last;
		logic  k_last;
		logic  out_free;
	} stat_t;

endpackage

// ===== design/all_pairs_shortest_path_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_table
// Direct and shortest distance matrices with Floyd-Warshall recompute on
// every edge update, and distance queries.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// request   req_valid / req_stall       opcode, node_a, node_b, edge_weight
// result    rsp_valid / rsp_stall       path_length, reachable, status
// config    psel / penable / pready     paddr, pwdata, prdata
//
// A set-edge request writes the edge, copies the direct matrix and relaxes over
// the n active nodes with the one add and compare unit, one entry a cycle within
// a row. After reset an initialization pass over every entry writes both
// matrices, with req_stall high. A new request is taken while the previous
// result waits; a held result only stalls the block at the end of the
// following request.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_table #(
	parameter int MAX_NODES = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [apspt_pkg::PADDR_W-1:0]      paddr,
	input  logic [apspt_pkg::PDATA_W-1:0]      pwdata,
	output logic [apspt_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [apspt_pkg::OPCODE_W-1:0]     opcode,
	input  logic [apspt_pkg::NODE_W-1:0]       node_a,
	input  logic [apspt_pkg::NODE_W-1:0]       node_b,
	input  logic [apspt_pkg::WEIGHT_W-1:0]     edge_weight,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [apspt_pkg::WEIGHT_W-1:0]     path_length,
	output logic                               reachable,
	output logic [apspt_pkg::STATUS_W-1:0]     status
);

	logic [apspt_pkg::COUNT_W-1:0] node_count_q;
	logic                          sel_count;
	apspt_pkg::cmd_t               cmd;
	apspt_pkg::stat_t              stat;

	assign pready    = 1'b1;
	assign sel_count = (paddr[apspt_pkg::PADDR_W-1:2] == apspt_pkg::REG_NODE_COUNT);
	assign prdata    = sel_count ? apspt_pkg::PDATA_W'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_count) begin
			node_count_q <= pwdata[apspt_pkg::COUNT_W-1:0];
		end
	end

	apspt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	apspt_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.node_a      (node_a),
		.node_b      (node_b),
		.edge_weight (edge_weight),
		.node_count  (node_count_q),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.path_length (path_length),
		.reachable   (reachable),
		.status      (status)
	);

endmodule

// ===== design/apspt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apspt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apspt_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/apspt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apspt_ctrl
// Sequencer for matrix initialization, edge writes, the copy sweep, the
// relaxation loops and queries.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_path_table_assert.svh"

module apspt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output apspt_pkg::cmd_t cmd,
	input  apspt_pkg::stat_t stat
);

	typedef enum logic [12:0] {
		S_INIT    = 13'b0_0000_0000_0001,
		S_IDLE    = 13'b0_0000_0000_0010,
		S_DECODE  = 13'b0_0000_0000_0100,
		S_CLEAR   = 13'b0_0000_0000_1000,
		S_EDGE_AB = 13'b0_0000_0001_0000,
		S_EDGE_BA = 13'b0_0000_0010_0000,
		S_COPY    = 13'b0_0000_0100_0000,
		S_ROW_LD  = 13'b0_0000_1000_0000,
		S_ROW_WT  = 13'b0_0001_0000_0000,
		S_RELAX   = 13'b0_0010_0000_0000,
		S_Q_RD    = 13'b0_0100_0000_0000,
		S_Q_WT    = 13'b0_1000_0000_0000,
		S_RESULT  = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.kind)
					apspt_pkg::KIND_CLEAR: state_d = S_CLEAR;
					apspt_pkg::KIND_EDGE:  state_d = S_EDGE_AB;
					apspt_pkg::KIND_QUERY: state_d = S_Q_RD;
					apspt_pkg::KIND_NONE:  state_d = S_RESULT;
				endcase
			end
			S_CLEAR: begin
				cmd.init_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_RESULT;
				end
			end
			S_EDGE_AB: begin
				cmd.edge_ab = 1'b1;
				state_d     = S_EDGE_BA;
			end
			S_EDGE_BA: begin
				cmd.edge_ba = 1'b1;
				state_d     = S_COPY;
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_ROW_LD;
				end
			end
			S_ROW_LD: begin
				cmd.ik_read = 1'b1;
				state_d     = S_ROW_WT;
			end
			S_ROW_WT: begin
				cmd.ik_load = 1'b1;
				state_d     = S_RELAX;
			end
			S_RELAX: begin
				cmd.relax_step = 1'b1;
				if (stat.j_last && stat.i_last && stat.k_last) begin
					state_d = S_RESULT;
				end else if (stat.j_last) begin
					state_d = S_ROW_LD;
				end
			end
			S_Q_RD: begin
				cmd.query_read = 1'b1;
				state_d        = S_Q_WT;
			end
			S_Q_WT: begin
				cmd.query_load = 1'b1;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	`APSPT_ASSERT(a_accept_to_decode, clk, arst_n, (req_valid && !req_stall) |=> (state_q == S_DECODE), "accepted request did not move to decode")

endmodule

// ===== design/apspt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apspt_dp
// Request registers, sweep and loop counters, the direct and shortest
// matrices, the shared add and compare unit and the result register.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_path_table_assert.svh"

module apspt_dp #(
	parameter int MAX_NODES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  apspt_pkg::cmd_t                   cmd,
	output apspt_pkg::stat_t                  stat,
	input  logic [apspt_pkg::OPCODE_W-1:0]    opcode,
	input  logic [apspt_pkg::NODE_W-1:0]      node_a,
	input  logic [apspt_pkg::NODE_W-1:0]      node_b,
	input  logic [apspt_pkg::WEIGHT_W-1:0]    edge_weight,
	input  logic [apspt_pkg::COUNT_W-1:0]     node_count,
	input  logic                              rsp_stall,
	output logic                              rsp_valid,
	output logic [apspt_pkg::WEIGHT_W-1:0]    path_length,
	output logic                              reachable,
	output logic [apspt_pkg::STATUS_W-1:0]    status
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int CMPW  = (CW > apspt_pkg::COUNT_W) ? CW : apspt_pkg::COUNT_W;
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam int WW    = apspt_pkg::WEIGHT_W;

	// Captured request.
	apspt_pkg::opcode_t      op_q;
	logic [apspt_pkg::NODE_W-1:0] a_q;
	logic [apspt_pkg::NODE_W-1:0] b_q;
	logic [WW-1:0]           w_q;

	logic [CW-1:0]   n_eff;
	logic            range_bad;
	logic [NW-1:0]   a_idx;
	logic [NW-1:0]   b_idx;
	apspt_pkg::status_t st;
	apspt_pkg::kind_t   kind;

	// Counters.
	logic [NW-1:0] row_q, col_q;
	logic [NW-1:0] k_q, i_q, j_q;
	logic          col_last, sweep_last, j_last, i_last, k_last;

	// Memory ports.
	logic          dir_we;
	logic [AW-1:0] dir_waddr;
	logic [WW-1:0] dir_wdata;
	logic [WW-1:0] dir_rd;
	logic          sh_we;
	logic [AW-1:0] sh_waddr;
	logic [WW-1:0] sh_wdata;
	logic [AW-1:0] sha_raddr;
	logic [WW-1:0] sha_rd;
	logic [WW-1:0] shb_rd;
	logic [WW-1:0] init_val;

	// Write-back stage for the copy sweep and the relaxation.
	logic          copy_s1;
	logic          relax_s1;
	logic [AW-1:0] addr_s1;
	logic [WW-1:0] d_ik_q;
	logic [apspt_pkg::SUM_W-1:0] sum;
	logic          relax_wr;
	logic [WW-1:0] len_q;

	logic          rsp_valid_q;
	logic [WW-1:0] path_q;
	logic          reach_q;
	apspt_pkg::status_t status_q;
	logic          out_free;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= apspt_pkg::opcode_t'(opcode);
			a_q  <= node_a;
			b_q  <= node_b;
			w_q  <= (edge_weight > apspt_pkg::NO_EDGE) ? apspt_pkg::NO_EDGE : edge_weight;
		end
	end

	// A node count above the matrix size acts as the matrix size.
	assign n_eff = (CMPW'(node_count) > CMPW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);
	assign range_bad = (CMPW'(a_q) >= CMPW'(n_eff)) || (CMPW'(b_q) >= CMPW'(n_eff));
	assign a_idx = NW'(a_q);
	assign b_idx = NW'(b_q);

	always_comb begin
		st   = apspt_pkg::ST_OK;
		kind = apspt_pkg::KIND_NONE;
		unique case (op_q)
			apspt_pkg::OP_CLEAR: kind = apspt_pkg::KIND_CLEAR;
			apspt_pkg::OP_SET_EDGE: begin
				if (range_bad) begin
					st = apspt_pkg::ST_RANGE;
				end else if (a_q == b_q) begin
					st = apspt_pkg::ST_SELF;
				end else begin
					kind = apspt_pkg::KIND_EDGE;
				end
			end
			apspt_pkg::OP_QUERY: begin
				if (range_bad) begin
					st = apspt_pkg::ST_RANGE;
				end else begin
					kind = apspt_pkg::KIND_QUERY;
				end
			end
			apspt_pkg::OP_NONE: kind = apspt_pkg::KIND_NONE;
			// Before the first request is captured the opcode is unknown.
			default: kind = apspt_pkg::KIND_NONE;
		endcase
	end

	// Sweep counters walk every entry of the matrix and wrap to zero at the end.
	assign col_last   = (col_q == NW'(MAX_NODES - 1));
	assign sweep_last = col_last && (row_q == NW'(MAX_NODES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.init_step || cmd.copy_step) begin
			if (sweep_last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_last) begin
				row_q <= row_q + NW'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + NW'(1);
			end
		end
	end

	// Relaxation loops over the active nodes: k outermost, j innermost.
	assign j_last = ((CW'(j_q) + CW'(1)) == n_eff);
	assign i_last = ((CW'(i_q) + CW'(1)) == n_eff);
	assign k_last = ((CW'(k_q) + CW'(1)) == n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.relax_step) begin
			if (j_last) begin
				j_q <= '0;
				if (i_last) begin
					i_q <= '0;
					k_q <= k_last ? '0 : k_q + NW'(1);
				end else begin
					i_q <= i_q + NW'(1);
				end
			end else begin
				j_q <= j_q + NW'(1);
			end
		end
	end

	assign init_val = (row_q == col_q) ? '0 : apspt_pkg::NO_EDGE;

	// Direct matrix: written by the init sweep and by edge writes, read by the copy.
	assign dir_we = cmd.init_step || cmd.edge_ab || cmd.edge_ba;

	always_comb begin
		priority if (cmd.init_step) begin
			dir_waddr = {row_q, col_q};
			dir_wdata = init_val;
		end else if (cmd.edge_ab) begin
			dir_waddr = {a_idx, b_idx};
			dir_wdata = w_q;
		end else begin
			dir_waddr = {b_idx, a_idx};
			dir_wdata = w_q;
		end
	end

	apspt_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_direct (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr ({row_q, col_q}),
		.rdata (dir_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1  <= 1'b0;
			relax_s1 <= 1'b0;
		end else begin
			copy_s1  <= cmd.copy_step;
			relax_s1 <= cmd.relax_step;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cmd.copy_step ? {row_q, col_q} : {i_q, j_q};
		if (cmd.ik_load) begin
			d_ik_q <= sha_rd;
		end
	end

	assign sum      = {1'b0, d_ik_q} + {1'b0, sha_rd};
	assign relax_wr = relax_s1 && (sum < {1'b0, shb_rd});

	always_comb begin
		sh_we = cmd.init_step || copy_s1 || relax_wr;
		priority if (cmd.init_step) begin
			sh_waddr = {row_q, col_q};
			sh_wdata = init_val;
		end else if (copy_s1) begin
			sh_waddr = addr_s1;
			sh_wdata = dir_rd;
		end else begin
			sh_waddr = addr_s1;
			sh_wdata = sum[WW-1:0];
		end
	end

	always_comb begin
		priority if (cmd.query_read) begin
			sha_raddr = {a_idx, b_idx};
		end else if (cmd.ik_read) begin
			sha_raddr = {i_q, k_q};
		end else begin
			sha_raddr = {k_q, j_q};
		end
	end

	// The shortest matrix is kept twice so that both relaxation operands
	// can be read in the same cycle.
	apspt_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_shortest_a (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata),
		.raddr (sha_raddr),
		.rdata (sha_rd)
	);

	apspt_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_shortest_b (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata),
		.raddr ({i_q, j_q}),
		.rdata (shb_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			len_q <= (sha_rd > apspt_pkg::NO_EDGE) ? apspt_pkg::NO_EDGE : sha_rd;
		end
	end

	// Result register.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			path_q   <= (kind == apspt_pkg::KIND_QUERY) ? len_q : '0;
			reach_q  <= (kind == apspt_pkg::KIND_QUERY) && (len_q < apspt_pkg::NO_EDGE);
			status_q <= st;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign path_length = path_q;
	assign reachable   = reach_q;
	assign status      = status_q;

	assign stat.kind       = kind;
	assign stat.sweep_last = sweep_last;
	assign stat.j_last     = j_last;
	assign stat.i_last     = i_last;
	assign stat.k_last     = k_last;
	assign stat.out_free   = out_free;

	`APSPT_ASSERT(a_relax_bounded, clk, arst_n, relax_wr |-> (sum <= {1'b0, apspt_pkg::NO_EDGE}), "relaxation stored a distance above the no-edge value")
	`APSPT_ASSERT_NEVER(a_write_clash, clk, arst_n, (cmd.init_step && (copy_s1 || relax_s1)) || (copy_s1 && relax_s1), "two writers on the shortest matrix")
	`APSPT_ASSERT(a_result_room, clk, arst_n, cmd.result_load |-> out_free, "result loaded over one not yet taken")

endmodule
